### sv/websocket_frame_deframer_unit_assert.svh
// Assertion macros used by the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Implication checked on every rising edge of aclk, off while in reset.
`define WSFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wsfd assertion failed");

// Next-cycle implication, off while in reset.
`define WSFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wsfd assertion failed");

`endif

### sv/wsfd_pkg.sv
// Types and constants shared by the WebSocket deframer modules.
package wsfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 64;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 3;
    localparam int USER_W  = 7;

    localparam logic [6:0]       LEN7_EXT16 = 7'd126;
    localparam logic [6:0]       LEN7_EXT64 = 7'd127;
    localparam logic [CNT_W-1:0] EXT16_LAST = 3'd1;
    localparam logic [CNT_W-1:0] EXT64_LAST = 3'd7;
    localparam logic [CNT_W-1:0] KEY_LAST   = 3'd3;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_KEY,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic              frame_fin;
        logic [3:0]        frame_opcode;
        logic              was_masked;
        logic              last_of_frame;
    } result_t;

endpackage

### sv/wsfd_in_stage.sv
// Input register holding one frame byte ahead of the parser.
module wsfd_in_stage (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,
    input  logic                     advance,
    output wsfd_pkg::in_item_t       in_item
);
    import wsfd_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            data_next  = s_tdata;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign in_item.valid = valid_reg;
    assign in_item.data  = data_reg;

endmodule

### sv/wsfd_parser.sv
// Frame header parser, key store and payload unmasking.
module wsfd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic [7:0]          frame_byte,
    output logic                res_valid,
    output wsfd_pkg::result_t   res
);
    import wsfd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [1:0]         kidx_reg, kidx_next;
    logic               fin_reg, fin_next;
    logic [3:0]         op_reg, op_next;
    logic               mask_reg, mask_next;
    logic               long_reg, long_next;

    logic [6:0]         len7;
    logic               len_is_ext;
    logic [LEN_W-1:0]   rem_sh;
    logic               ext_done;
    logic               key_done;
    logic [BYTE_W-1:0]  key_byte;

    assign len7       = frame_byte[6:0];
    assign len_is_ext = (len7 == LEN7_EXT16) || (len7 == LEN7_EXT64);
    assign rem_sh     = {rem_reg[LEN_W-BYTE_W-1:0], frame_byte};
    assign ext_done   = (cnt_reg == (long_reg ? EXT64_LAST : EXT16_LAST));
    assign key_done   = (cnt_reg == KEY_LAST);
    assign key_byte   = mask_reg ? key_reg[{kidx_reg, 3'b000} +: BYTE_W] : '0;

    // next state
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        key_next   = key_reg;
        kidx_next  = kidx_reg;
        fin_next   = fin_reg;
        op_next    = op_reg;
        mask_next  = mask_reg;
        long_next  = long_reg;
        if (take) begin
            case (phase_reg)
                PH_HDR1: begin
                    mask_next = frame_byte[7];
                    cnt_next  = '0;
                    if (len_is_ext) begin
                        long_next  = (len7 == LEN7_EXT64);
                        rem_next   = '0;
                        phase_next = PH_EXT;
                    end else begin
                        long_next = 1'b0;
                        rem_next  = {{(LEN_W-7){1'b0}}, len7};
                        if (frame_byte[7]) begin
                            phase_next = PH_KEY;
                        end else begin
                            kidx_next  = '0;
                            phase_next = (len7 == '0) ? PH_HDR0 : PH_DATA;
                        end
                    end
                end
                PH_EXT: begin
                    rem_next = rem_sh;
                    cnt_next = cnt_reg + 1'b1;
                    if (ext_done) begin
                        cnt_next = '0;
                        if (mask_reg) begin
                            phase_next = PH_KEY;
                        end else begin
                            kidx_next  = '0;
                            phase_next = (rem_sh == '0) ? PH_HDR0 : PH_DATA;
                        end
                    end
                end
                PH_KEY: begin
                    key_next[{cnt_reg[1:0], 3'b000} +: BYTE_W] = frame_byte;
                    cnt_next = cnt_reg + 1'b1;
                    if (key_done) begin
                        cnt_next   = '0;
                        kidx_next  = '0;
                        phase_next = (rem_reg == '0) ? PH_HDR0 : PH_DATA;
                    end
                end
                PH_DATA: begin
                    kidx_next = kidx_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                    if (rem_reg == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    fin_next   = frame_byte[7];
                    op_next    = frame_byte[3:0];
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    // result
    always_comb begin
        res_valid         = 1'b0;
        res.payload_byte  = '0;
        res.payload_valid = 1'b0;
        res.frame_fin     = fin_reg;
        res.frame_opcode  = op_reg;
        res.was_masked    = mask_reg;
        res.last_of_frame = 1'b1;
        if (take) begin
            case (phase_reg)
                PH_HDR1: begin
                    res.was_masked = frame_byte[7];
                    res_valid = !len_is_ext && !frame_byte[7] && (len7 == '0);
                end
                PH_EXT: begin
                    res_valid = ext_done && !mask_reg && (rem_sh == '0);
                end
                PH_KEY: begin
                    res_valid = key_done && (rem_reg == '0);
                end
                PH_DATA: begin
                    res_valid         = 1'b1;
                    res.payload_byte  = frame_byte ^ key_byte;
                    res.payload_valid = 1'b1;
                    res.last_of_frame = (rem_reg == {{(LEN_W-1){1'b0}}, 1'b1});
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            key_reg   <= '0;
            kidx_reg  <= '0;
            fin_reg   <= 1'b0;
            op_reg    <= '0;
            mask_reg  <= 1'b0;
            long_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            key_reg   <= key_next;
            kidx_reg  <= kidx_next;
            fin_reg   <= fin_next;
            op_reg    <= op_next;
            mask_reg  <= mask_next;
            long_reg  <= long_next;
        end
    end

endmodule

### sv/wsfd_out_buf.sv
// Two-entry result buffer decoupling the parser from the output handshake.
module wsfd_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wsfd_pkg::result_t   push_item,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output wsfd_pkg::result_t   m_item
);
    import wsfd_pkg::*;

    result_t     mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign m_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer.
//  channel  | dir | tdata             | tuser (lsb up)                          | tlast
//  s_ input | in  | [7:0] frame_byte  | -                                       | -
//  m_ out   | out | [7:0] payload_byte| payload_valid, frame_fin, frame_opcode, | last_of_frame
//           |     |                   | was_masked                              |
// One byte per cycle sustained while the result buffer is not full; a byte waits in the input
// register, is parsed once the buffer has room, and its result is written to the buffer at the
// edge that frees the input register, so the m_ transfer of that result comes from the buffer.
// Reset: synchronous, active low; parser returns to expecting a first header byte.
// Stalls: a two-entry result buffer absorbs m_tready low; s_tready drops only
// while the buffer is full and a byte waits in the input register.
module websocket_frame_deframer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] frame_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [6:0] m_tuser,   // [0] payload_valid, [1] frame_fin,
                                  // [5:2] frame_opcode, [6] was_masked
    output logic       m_tlast    // last_of_frame
);
    import wsfd_pkg::*;

    in_item_t in_item;
    result_t  res;
    result_t  out_item;
    logic     res_valid;
    logic     out_full;
    logic     advance;

    assign advance = in_item.valid && !out_full;

    wsfd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_item  (in_item)
    );

    wsfd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (advance),
        .frame_byte (in_item.data),
        .res_valid  (res_valid),
        .res        (res)
    );

    wsfd_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_item (res),
        .full      (out_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_item    (out_item)
    );

    assign m_tdata = out_item.payload_byte;
    assign m_tuser = {out_item.was_masked, out_item.frame_opcode,
                      out_item.frame_fin, out_item.payload_valid};
    assign m_tlast = out_item.last_of_frame;

endmodule

### sv/wsfd_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "websocket_frame_deframer_unit_assert.svh"

module wsfd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [6:0] m_tuser,
    input logic       m_tlast
);

    `WSFD_ASSERT_NEXT(a_m_valid_holds, m_tvalid && !m_tready, m_tvalid)
    `WSFD_ASSERT_NEXT(a_m_data_holds, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `WSFD_ASSERT_IMPL(a_empty_marked, m_tvalid && !m_tuser[0], m_tlast && (m_tdata == 8'd0))
    `WSFD_ASSERT_IMPL(a_result_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
